// ===== rtl/hias_pkg.sv =====
// Package with the constants, types and hash helper of the hashed id set.
`timescale 1ns / 1ps
package hias_pkg;

  localparam int BUCKET_BITS = 8;
  localparam int ENTRY_COUNT = 1024;
  localparam int KEY_BITS    = 64;

  localparam int BUCKETS     = 1 << BUCKET_BITS;
  localparam int IDX_BITS    = $clog2(ENTRY_COUNT);
  localparam int CNT_BITS    = $clog2(ENTRY_COUNT + 1);

  // Fixed widths of the channel fields.
  localparam int KEY_W   = 64;
  localparam int HASH_W  = 32;
  localparam int ID_W    = 10;
  localparam int STAT_W  = 2;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_GET   = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND = 2'd0,
    ST_NEW   = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_MISS,
    S_FINISH
  } state_t;

  // A chain link: an entry index, or the end of the chain when nil is set.
  typedef struct packed {
    logic                nil;
    logic [IDX_BITS-1:0] idx;
  } link_t;

  // Low bucket bits of (h<<7) - h + (h>>9) + (h>>17). Carries only move
  // upward, so the sum is formed at bucket width.
  function automatic logic [BUCKET_BITS-1:0] mix_bucket(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] s7;
    logic [HASH_W-1:0] s9;
    logic [HASH_W-1:0] s17;
    s7  = h << 7;
    s9  = h >> 9;
    s17 = h >> 17;
    return s7[BUCKET_BITS-1:0] - h[BUCKET_BITS-1:0]
         + s9[BUCKET_BITS-1:0] + s17[BUCKET_BITS-1:0];
  endfunction

endpackage

// ===== rtl/hias_if.sv =====
// Valid/ready channel interfaces for request and result words.
`timescale 1ns / 1ps
interface hias_in_if import hias_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [KEY_W-1:0]  key;
  logic [HASH_W-1:0] hash_in;

  modport source (output valid, output func, output key, output hash_in, input ready);
  modport sink   (input valid, input func, input key, input hash_in, output ready);
endinterface

interface hias_out_if import hias_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   id;

  modport source (output valid, output status, output id, input ready);
  modport sink   (input valid, input status, input id, output ready);
endinterface

// ===== rtl/hashed_id_assigning_set_top.sv =====
// Hashed id-assigning set: bucket heads, entry pool and chain-walk sequencer.
//
// Usage: each request word on in_ch carries func (store or get), a key and
// the caller's raw hash. The hash is mixed and masked to a bucket, and the
// bucket's chain is walked one entry per cycle through a single key
// comparator. Exactly one result word leaves on out_ch: status (found,
// inserted, not found, pool full) and the id of the match when found.
// A store that misses links a new entry at the head of the chain; its id is
// the number of entries stored before it.
// From acceptance a request passes through S_HEAD, then S_WALK for each
// chain entry visited, then S_MISS and S_FINISH; an empty chain skips
// S_WALK, and a hit stops on the matching entry and skips S_MISS. The chain
// walk through the entry memory read port sets the rate; in_ch.ready is high
// only while the sequencer is idle, so one request is in flight at a time and
// the next one is taken in the cycle after a result is registered.
// A finished result sits in the output register; when the receiver stalls,
// the sequencer holds the next result until that register is taken.
// Reset clears all bucket valid bits and the entry count at once, so the
// block is ready in the first cycle after reset with no clearing pass.
`timescale 1ns / 1ps
module hashed_id_assigning_set_top import hias_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hias_in_if.sink     in_ch,
  hias_out_if.source  out_ch
);

  state_t state_r, state_nxt;

  // Bucket head memory plus a valid bit per bucket.
  logic [IDX_BITS-1:0]    head_mem [BUCKETS];
  logic [BUCKETS-1:0]     head_vld_r;
  logic [IDX_BITS-1:0]    head_q_r;

  // Entry pool memories.
  logic [KEY_BITS-1:0]    key_mem  [ENTRY_COUNT];
  link_t                  next_mem [ENTRY_COUNT];
  logic [KEY_BITS-1:0]    key_q_r;
  link_t                  next_q_r;

  logic                   func_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [BUCKET_BITS-1:0] bucket_r;
  link_t                  head_link_r;
  logic [IDX_BITS-1:0]    cur_r;
  logic [CNT_BITS-1:0]    count_r;

  status_t                res_status_r;
  logic [ID_W-1:0]        res_id_r;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [ID_W-1:0]        out_id_r;

  logic                   in_fire;
  logic [BUCKET_BITS-1:0] in_bucket;
  link_t                  head_link;
  logic                   key_eq;
  logic                   pool_full;
  logic                   do_insert;
  logic                   ent_rd_en;
  logic [IDX_BITS-1:0]    ent_rd_addr;
  logic                   out_free;
  logic [IDX_BITS-1:0]    slot;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_bucket = mix_bucket(in_ch.hash_in);
  assign head_link = '{nil: ~head_vld_r[bucket_r], idx: head_q_r};
  assign key_eq    = (key_q_r == key_r);
  assign pool_full = (count_r == CNT_BITS'(ENTRY_COUNT));
  assign slot      = count_r[IDX_BITS-1:0];
  assign out_free  = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_HEAD;
      end
      S_HEAD: begin
        state_nxt = head_link.nil ? S_MISS : S_WALK;
      end
      S_WALK: begin
        if (key_eq) state_nxt = S_FINISH;
        else if (next_q_r.nil) state_nxt = S_MISS;
      end
      S_MISS: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ch.ready = 1'b0;
    ent_rd_en   = 1'b0;
    ent_rd_addr = head_link.idx;
    do_insert   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
      end
      S_HEAD: begin
        ent_rd_en   = !head_link.nil;
        ent_rd_addr = head_link.idx;
      end
      S_WALK: begin
        ent_rd_en   = !key_eq && !next_q_r.nil;
        ent_rd_addr = next_q_r.idx;
      end
      S_MISS: begin
        do_insert = (func_r == FUNC_STORE) && !pool_full;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_vld_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_insert) begin
        head_vld_r[bucket_r] <= 1'b1;
        count_r              <= count_r + CNT_BITS'(1);
      end
      if (state_r == S_FINISH && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Bucket head memory: read on acceptance, written on insert.
  always_ff @(posedge clk) begin
    if (in_fire) head_q_r <= head_mem[in_bucket];
    if (do_insert) head_mem[bucket_r] <= slot;
  end

  // Entry pool: one read port for the walk, one write port for inserts.
  always_ff @(posedge clk) begin
    if (ent_rd_en) begin
      key_q_r  <= key_mem[ent_rd_addr];
      next_q_r <= next_mem[ent_rd_addr];
    end
    if (do_insert) begin
      key_mem[slot]  <= key_r;
      next_mem[slot] <= head_link_r;
    end
  end

  // Request and walk registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r   <= in_ch.func;
      key_r    <= in_ch.key[KEY_BITS-1:0];
      bucket_r <= in_bucket;
    end
    if (state_r == S_HEAD) head_link_r <= head_link;
    if (ent_rd_en) cur_r <= ent_rd_addr;
    if (state_r == S_WALK && key_eq) begin
      res_status_r <= ST_FOUND;
      res_id_r     <= ID_W'(cur_r);
    end
    if (state_r == S_MISS) begin
      res_id_r <= '0;
      if (func_r == FUNC_GET) res_status_r <= ST_MISS;
      else if (pool_full) res_status_r <= ST_FULL;
      else res_status_r <= ST_NEW;
    end
    if (state_r == S_FINISH && out_free) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.id     = out_id_r;

endmodule
